@@ hdl/bftr_pkg.sv @@
// Package for the bitmap font text renderer.
// Holds the 5x7 glyph table, character codes and shared constants.
// No dependencies.
package bftr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 7;
  localparam int GLYPH_BITS     = GLYPH_COLS * GLYPH_ROWS;
  localparam int LINE_STEP      = 8;
  localparam int CHAR_STEP      = 6;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
  localparam logic [7:0] CHAR_CASE    = 8'h20;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h5F;

  // Column c of a glyph sits in bits [c*8 +: 8], row r at bit r of that byte.
  localparam logic [39:0] GLYPH_ROM [0:63] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h12_2A_7F_2A_24, 40'h62_64_08_13_23, 40'h50_22_55_49_36, 40'h00_00_03_05_00,
    40'h00_41_22_1C_00, 40'h00_1C_22_41_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
    40'h00_00_30_50_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h02_04_08_10_20,
    40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
    40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
    40'h36_49_49_49_36, 40'h1E_29_49_49_06, 40'h00_00_36_36_00, 40'h00_00_36_56_00,
    40'h41_22_14_08_00, 40'h14_14_14_14_14, 40'h00_08_14_22_41, 40'h06_09_51_01_02,
    40'h3E_41_79_49_32, 40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E,
    40'h1C_22_41_41_7F, 40'h41_49_49_49_7F, 40'h01_01_09_09_7F, 40'h32_51_41_41_3E,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F,
    40'h40_40_40_40_7F, 40'h7F_02_04_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E,
    40'h06_09_09_09_7F, 40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h31_49_49_49_46,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
    40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h43_45_49_51_61, 40'h00_41_41_7F_00,
    40'h20_10_08_04_02, 40'h00_7F_41_41_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40
  };

endpackage

@@ hdl/bitmap_font_text_rect_generator_top.sv @@
// The first square of a character passes through the queue, the back end's command
// registers and the output register before it reaches the result ports. The back end
// emits one square per cycle, one for each set glyph bit, while its output is empty
// or popped; the front end accepts one character per cycle while the 4-entry queue has room.
// Reset clears the cursor, line start, queue pointers and the back end's active and valid flags.
module bitmap_font_text_rect_generator_top #(
  parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               start_req,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic [7:0]         char_code,
  input  logic [15:0]        color,
  input  logic [3:0]         scale,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] rect_x,
  output logic signed [15:0] rect_y,
  output logic [3:0]         rect_size,
  output logic [15:0]        rect_color,
  output logic               last
);

  localparam int CMD_W = 2 * COORD_BITS + bftr_pkg::GLYPH_BITS + 20;

  logic             accept;
  logic             cmd_push, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_wr, cmd_rd;

  assign accept = push && !full;

  bftr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .start_req (start_req),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .char_code (char_code),
    .color     (color),
    .scale     (scale),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wr)
  );

  bftr_queue #(.WIDTH(CMD_W), .DEPTH(bftr_pkg::QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .full    (full),
    .empty   (cmd_empty)
  );

  bftr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_rd),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_size  (rect_size),
    .rect_color (rect_color),
    .last       (last)
  );

endmodule

@@ hdl/bftr_front.sv @@
// Front end of the text renderer: accepts characters, tracks the cursor and
// turns each drawable character into a glyph command for the queue.
// Depends on bftr_pkg.
module bftr_front #(
  parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEF,
  localparam int CMD_W = 2 * COORD_BITS + bftr_pkg::GLYPH_BITS + 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 start_req,
  input  logic signed [15:0]   origin_x,
  input  logic signed [15:0]   origin_y,
  input  logic [7:0]           char_code,
  input  logic [15:0]          color,
  input  logic [3:0]           scale,
  output logic                 cmd_push,
  output logic [CMD_W-1:0]     cmd_data
);

  logic [COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic [COORD_BITS-1:0] line_start_x, line_start_x_next;

  logic [31:0]           ox_ext, oy_ext;
  logic [COORD_BITS-1:0] cx, cy, lx;
  logic [3:0]            s_eff;
  logic [7:0]            code_up;
  logic [5:0]            glyph_idx;
  logic [39:0]           glyph;
  logic [bftr_pkg::GLYPH_BITS-1:0] mask;
  logic                  is_newline;
  logic [6:0]            line_step, char_step;

  always_comb begin
    ox_ext = {{16{origin_x[15]}}, origin_x};
    oy_ext = {{16{origin_y[15]}}, origin_y};
    s_eff  = (scale == 4'd0) ? 4'd1 : scale;
    if (start_req) begin
      cx = ox_ext[COORD_BITS-1:0];
      cy = oy_ext[COORD_BITS-1:0];
      lx = ox_ext[COORD_BITS-1:0];
    end else begin
      cx = cursor_x;
      cy = cursor_y;
      lx = line_start_x;
    end
    code_up = char_code;
    if (char_code inside {[bftr_pkg::CHAR_LOW_A:bftr_pkg::CHAR_LOW_Z]}) begin
      code_up = char_code - bftr_pkg::CHAR_CASE;
    end
    glyph_idx = 6'd0;
    if (code_up inside {[bftr_pkg::CHAR_FIRST:bftr_pkg::CHAR_LAST]}) begin
      glyph_idx = 6'(code_up - bftr_pkg::CHAR_FIRST);
    end
    glyph = bftr_pkg::GLYPH_ROM[glyph_idx];
    for (int c = 0; c < bftr_pkg::GLYPH_COLS; c++) begin
      for (int r = 0; r < bftr_pkg::GLYPH_ROWS; r++) begin
        mask[c * bftr_pkg::GLYPH_ROWS + r] = glyph[c * 8 + r];
      end
    end
    is_newline = (char_code == bftr_pkg::CHAR_NEWLINE);
    line_step  = 7'(s_eff) * 7'(bftr_pkg::LINE_STEP);
    char_step  = 7'(s_eff) * 7'(bftr_pkg::CHAR_STEP);

    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    line_start_x_next = line_start_x;
    if (accept) begin
      line_start_x_next = lx;
      if (is_newline) begin
        cursor_x_next = lx;
        cursor_y_next = cy + COORD_BITS'(line_step);
      end else begin
        cursor_x_next = cx + COORD_BITS'(char_step);
        cursor_y_next = cy;
      end
    end

    cmd_push = accept && !is_newline && (mask != '0);
    cmd_data = {cx, cy, mask, s_eff, color};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
    end else begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      line_start_x <= line_start_x_next;
    end
  end

endmodule

@@ hdl/bftr_queue.sv @@
// Short command queue between the front and back ends of the renderer.
// Depends on bftr_pkg for its depth default.
module bftr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bftr_pkg::QUEUE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wr_ptr, rd_ptr, count;

  assign count   = wr_ptr - rd_ptr;
  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr[AW-1:0] == AW'(DEPTH - 1)) ?
                  {~wr_ptr[AW], {AW{1'b0}}} : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr[AW-1:0] == AW'(DEPTH - 1)) ?
                  {~rd_ptr[AW], {AW{1'b0}}} : rd_ptr + 1'b1;
      end
    end
  end

endmodule

@@ hdl/bftr_back.sv @@
// Back end of the renderer: walks the set bits of one glyph command and
// emits one square per beat into the output register. Depends on bftr_pkg.
module bftr_back #(
  parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEF,
  localparam int CMD_W = 2 * COORD_BITS + bftr_pkg::GLYPH_BITS + 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  logic [CMD_W-1:0]   cmd_data,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [15:0] rect_x,
  output logic signed [15:0] rect_y,
  output logic [3:0]         rect_size,
  output logic [15:0]        rect_color,
  output logic               last
);

  logic                            active, active_next;
  logic [COORD_BITS-1:0]           base_x, base_y;
  logic [bftr_pkg::GLYPH_BITS-1:0] mask, mask_next, mask_left;
  logic [3:0]                      size;
  logic [15:0]                     fill;
  logic                            out_valid, out_valid_next;

  logic [2:0]            sel_col, sel_row;
  logic [6:0]            dx, dy;
  logic [COORD_BITS-1:0] px, py;
  logic [31:0]           px_ext, py_ext;
  logic                  advance, finish;

  always_comb begin
    sel_col = '0;
    sel_row = '0;
    for (int c = bftr_pkg::GLYPH_COLS - 1; c >= 0; c--) begin
      for (int r = bftr_pkg::GLYPH_ROWS - 1; r >= 0; r--) begin
        if (mask[c * bftr_pkg::GLYPH_ROWS + r]) begin
          sel_col = 3'(c);
          sel_row = 3'(r);
        end
      end
    end
    mask_left = mask & (mask - 1'b1);
    dx        = 7'(sel_col) * 7'(size);
    dy        = 7'(sel_row) * 7'(size);
    px        = base_x + COORD_BITS'(dx);
    py        = base_y + COORD_BITS'(dy);
    px_ext    = 32'(px);
    py_ext    = 32'(py);

    advance        = active && (!out_valid || pop);
    finish         = advance && (mask_left == '0);
    cmd_pop        = !cmd_empty && (!active || finish);
    active_next    = cmd_pop ? 1'b1 : (finish ? 1'b0 : active);
    mask_next      = advance ? mask_left : mask;
    out_valid_next = advance ? 1'b1 : ((out_valid && pop) ? 1'b0 : out_valid);
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      {base_x, base_y, mask, size, fill} <= cmd_data;
    end else begin
      mask <= mask_next;
    end
    if (advance) begin
      rect_x     <= px_ext[15:0];
      rect_y     <= py_ext[15:0];
      rect_size  <= size;
      rect_color <= fill;
      last       <= (mask_left == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      active    <= active_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
